// ----- design/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication that is checked during reset as well.
`define ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- design/kwlr_pkg.sv -----
package kwlr_pkg;

   // Fixed sizes of the keyword table and of the line length field.
   localparam int KEY_MAX = 18;
   localparam int KEY_COUNT = 42;
   localparam int KEY_LEN_W = $clog2(KEY_MAX + 1);
   localparam int LINE_W = 13;
   localparam int LINE_LIMIT = 8191;
   localparam int MAX_LEN_DEFAULT = 4096;

   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] NUL_CHAR = 8'h00;

   typedef logic [7:0] byte_type;
   typedef logic [KEY_MAX*8-1:0] key_word_type;
   typedef logic [KEY_LEN_W-1:0] key_len_type;
   typedef logic [LINE_W-1:0] line_len_type;

   // One finished line as it leaves the block.
   typedef struct packed {
      line_len_type line_length;
      logic redact;
      logic ends_newline;
      logic buffer_done;
   } line_result_type;

   // What the line tracker reports for the byte at its input.
   typedef struct packed {
      logic emit;
      line_result_type result;
   } line_status_type;

   // Keywords, right aligned: the last character sits in the low byte.
   localparam key_word_type KEY_ROM [KEY_COUNT] = '{
      key_word_type'(88'h6176633a2064656e696564),
      key_word_type'(56'h753a723a6b7375),
      key_word_type'(48'h753a723a7375),
      key_word_type'(80'h753a723a6d616769736b),
      key_word_type'(88'h753a723a6c73706f736564),
      key_word_type'(80'h753a723a7a796769736b),
      key_word_type'(80'h753a723a617061746368),
      key_word_type'(80'h753a723a73756b697375),
      key_word_type'(88'h753a723a73757065727375),
      key_word_type'(64'h753a723a726f6f74),
      key_word_type'(136'h753a6f626a6563745f723a6d616769736b),
      key_word_type'(112'h753a6f626a6563745f723a6b7375),
      key_word_type'(144'h753a6f626a6563745f723a6c73706f736564),
      key_word_type'(136'h753a6f626a6563745f723a7a796769736b),
      key_word_type'(136'h753a6f626a6563745f723a617061746368),
      key_word_type'(136'h753a6f626a6563745f723a73756b697375),
      key_word_type'(48'h6d616769736b),
      key_word_type'(56'h6c73706f736564),
      key_word_type'(48'h7a796769736b),
      key_word_type'(48'h617061746368),
      key_word_type'(48'h73756b697375),
      key_word_type'(56'h73757065727375),
      key_word_type'(64'h6b65726e656c7375),
      key_word_type'(88'h6b65726e656c7061746368),
      key_word_type'(40'h6b70696d67),
      key_word_type'(56'h6b70746f6f6c73),
      key_word_type'(56'h6d616769736b64),
      key_word_type'(96'h6d616769736b706f6c696379),
      key_word_type'(64'h7375706f6c696379),
      key_word_type'(32'h6b737564),
      key_word_type'(24'h617064),
      key_word_type'(56'h6b706174636864),
      key_word_type'(32'h6c737064),
      key_word_type'(64'h7a796769736b7375),
      key_word_type'(40'h7375736673),
      key_word_type'(96'h747269636b795f73746f7265),
      key_word_type'(56'h6e6f68656c6c6f),
      key_word_type'(72'h667573656669786572),
      key_word_type'(80'h686964657468616e6f78),
      key_word_type'(56'h686d615f6f7373),
      key_word_type'(104'h6368756e7169757a697975616e),
      key_word_type'(120'h73656c696e75783a2064656e696564)
   };

   // Keyword lengths in bytes, in table order.
   localparam key_len_type KEY_LEN [KEY_COUNT] = '{
      key_len_type'(11), key_len_type'(7),  key_len_type'(6),  key_len_type'(10),
      key_len_type'(11), key_len_type'(10), key_len_type'(10), key_len_type'(10),
      key_len_type'(11), key_len_type'(8),  key_len_type'(17), key_len_type'(14),
      key_len_type'(18), key_len_type'(17), key_len_type'(17), key_len_type'(17),
      key_len_type'(6),  key_len_type'(7),  key_len_type'(6),  key_len_type'(6),
      key_len_type'(6),  key_len_type'(7),  key_len_type'(8),  key_len_type'(11),
      key_len_type'(5),  key_len_type'(7),  key_len_type'(7),  key_len_type'(12),
      key_len_type'(8),  key_len_type'(4),  key_len_type'(3),  key_len_type'(7),
      key_len_type'(4),  key_len_type'(8),  key_len_type'(5),  key_len_type'(12),
      key_len_type'(7),  key_len_type'(9),  key_len_type'(10), key_len_type'(7),
      key_len_type'(13), key_len_type'(15)
   };

endpackage

// ----- design/kwlr_matcher.sv -----
module kwlr_matcher (
   input  kwlr_pkg::key_word_type window,
   input  kwlr_pkg::line_len_type line_count,
   output logic                   hit
);

   logic [kwlr_pkg::KEY_COUNT-1:0] key_ok;

   // Compare every keyword in parallel against the bytes that end at the newest one.
   // A keyword longer than the line so far cannot lie inside the line.
   always_comb begin
      for (int k = 0; k < kwlr_pkg::KEY_COUNT; k++) begin
         key_ok[k] = (kwlr_pkg::LINE_W'(kwlr_pkg::KEY_LEN[k]) <= line_count);
         for (int i = 0; i < kwlr_pkg::KEY_MAX; i++) begin
            if ((kwlr_pkg::key_len_type'(i) < kwlr_pkg::KEY_LEN[k]) &&
                (window[8*i +: 8] != kwlr_pkg::KEY_ROM[k][8*i +: 8])) begin
               key_ok[k] = 1'b0;
            end
         end
      end
   end

   assign hit = |key_ok;

endmodule

// ----- design/kwlr_line_state.sv -----
module kwlr_line_state #(
   parameter int MAX_LEN = kwlr_pkg::MAX_LEN_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  kwlr_pkg::byte_type        text_byte,
   input  logic                      final_byte,
   output kwlr_pkg::line_status_type status
);

   localparam int CAP_INT = (MAX_LEN < kwlr_pkg::LINE_LIMIT) ? MAX_LEN : kwlr_pkg::LINE_LIMIT;
   localparam kwlr_pkg::line_len_type LINE_CAP = kwlr_pkg::LINE_W'(CAP_INT);

   kwlr_pkg::key_word_type window_ff, window_in, window_next;
   kwlr_pkg::line_len_type line_count_ff, line_count_in, count_next;
   logic line_hit_ff, line_hit_in;
   logic split_stopped_ff, split_stopped_in;
   logic key_hit;
   logic nl_end;

   // Shift the new byte into the window, newest byte in the low position.
   assign window_next = kwlr_pkg::key_word_type'({window_ff, text_byte});

   // Line length saturates at the cap.
   assign count_next = (line_count_ff < LINE_CAP) ? line_count_ff + 1'b1 : line_count_ff;

   kwlr_matcher u_matcher (
      .window     (window_next),
      .line_count (count_next),
      .hit        (key_hit)
   );

   // A newline ends a line only until a zero byte has been seen in this buffer.
   assign nl_end = (text_byte == kwlr_pkg::NEWLINE_CHAR) && !split_stopped_ff;

   always_comb begin
      status.emit = nl_end || final_byte;
      status.result.line_length = count_next;
      status.result.redact = line_hit_ff || key_hit;
      status.result.ends_newline = nl_end;
      status.result.buffer_done = final_byte;
   end

   // Next state: a finished line clears its window, count and hit flag.
   always_comb begin
      window_in = window_ff;
      line_count_in = line_count_ff;
      line_hit_in = line_hit_ff;
      split_stopped_in = split_stopped_ff;
      if (step) begin
         if (status.emit) begin
            window_in = '0;
            line_count_in = '0;
            line_hit_in = 1'b0;
         end else begin
            window_in = window_next;
            line_count_in = count_next;
            line_hit_in = line_hit_ff || key_hit;
         end
         if (final_byte) begin
            split_stopped_in = 1'b0;
         end else if (text_byte == kwlr_pkg::NUL_CHAR) begin
            split_stopped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         line_count_ff <= '0;
         line_hit_ff <= 1'b0;
         split_stopped_ff <= 1'b0;
      end else begin
         window_ff <= window_in;
         line_count_ff <= line_count_in;
         line_hit_ff <= line_hit_in;
         split_stopped_ff <= split_stopped_in;
      end
   end

endmodule

// ----- design/keyword_line_redaction_marker.sv -----
// Keyword line redaction marker.
// Request channel: one text byte per request, with req_final_byte high on the
// last byte of a buffer. Response channel: one response per finished line, with
// its length, a redact flag when the line holds a keyword, whether it ends in a
// kept newline, and buffer_done on the last line of the buffer.
// A zero byte turns off line splitting for the rest of its buffer.
// A request taken is held in the input register; its response, if any, is then
// registered in the response register, which drives the response port.
// Throughput: one request per cycle while req_stall is low; the keyword compare
// against the window is parallel logic between the input and response registers.
// When the receiver stalls, the response register holds its line while bytes
// that do not end a line keep flowing through the input register; a byte that
// ends a line then waits there, and req_stall rises until the response register
// frees.
// Reset clears the window, the line count and flags, and the valid flags of both
// registers; the block takes requests in the first cycle after reset.
module keyword_line_redaction_marker #(
   parameter int MAX_LEN = kwlr_pkg::MAX_LEN_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_text_byte,
   input  logic                        req_final_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [kwlr_pkg::LINE_W-1:0] rsp_line_length,
   output logic                        rsp_redact,
   output logic                        rsp_ends_newline,
   output logic                        rsp_buffer_done
);

   logic in_vld_ff, in_vld_in;
   kwlr_pkg::byte_type in_byte_ff;
   logic in_final_ff;
   logic rsp_vld_ff, rsp_vld_in;
   kwlr_pkg::line_result_type rsp_data_ff;
   kwlr_pkg::line_status_type status;
   logic out_free;
   logic advance;
   logic load;

   kwlr_line_state #(
      .MAX_LEN (MAX_LEN)
   ) u_line_state (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .text_byte  (in_byte_ff),
      .final_byte (in_final_ff),
      .status     (status)
   );

   // Handshake control: the buffered byte moves on unless its line result has nowhere to go.
   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign advance = in_vld_ff && (!status.emit || out_free);
   assign req_stall = in_vld_ff && !advance;
   assign load = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (load) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (advance && status.emit) begin
         rsp_vld_in = 1'b1;
      end else if (out_free) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         in_byte_ff <= req_text_byte;
         in_final_ff <= req_final_byte;
      end
      if (advance && status.emit) begin
         rsp_data_ff <= status.result;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_line_length = rsp_data_ff.line_length;
   assign rsp_redact = rsp_data_ff.redact;
   assign rsp_ends_newline = rsp_data_ff.ends_newline;
   assign rsp_buffer_done = rsp_data_ff.buffer_done;

endmodule

// ----- design/kwlr_checker.sv -----
`include "assert_macros.svh"

module kwlr_checker #(
   parameter int MAX_LEN = kwlr_pkg::MAX_LEN_DEFAULT
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [kwlr_pkg::LINE_W-1:0] rsp_line_length,
   input logic                        rsp_redact,
   input logic                        rsp_ends_newline,
   input logic                        rsp_buffer_done
);

   localparam int CAP_INT = (MAX_LEN < kwlr_pkg::LINE_LIMIT) ? MAX_LEN : kwlr_pkg::LINE_LIMIT;
   localparam logic [kwlr_pkg::LINE_W-1:0] LINE_CAP = kwlr_pkg::LINE_W'(CAP_INT);

   logic line_end;
   logic len_ok;
   logic rsp_held;
   logic [kwlr_pkg::LINE_W+2:0] rsp_word;

   // Helper terms for the checks below.
   assign line_end = rsp_ends_newline || rsp_buffer_done;
   assign len_ok = (rsp_line_length != '0) && (rsp_line_length <= LINE_CAP);
   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_word = {rsp_line_length, rsp_redact, rsp_ends_newline, rsp_buffer_done};

   // A line result is only produced at a newline or at the end of a buffer.
   `ASSERT_IMPLY(a_line_end, clock, reset, rsp_valid, line_end, "response without a line end")

   // Every line holds at least one byte and never more than the cap.
   `ASSERT_IMPLY(a_len_range, clock, reset, rsp_valid, len_ok, "line length out of range")

   // No response is pending right after reset.
   `ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) && !reset, !rsp_valid, "response after reset")

   // A stalled response holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word), "response changed")

endmodule

bind keyword_line_redaction_marker kwlr_checker #(.MAX_LEN(MAX_LEN)) u_kwlr_checker (.*);
